// ===== hdl/nsc_pkg.sv =====
// Shared types, constants and tag tables for the NMEA sentence checker.
`default_nettype none
package nsc_pkg;

	// Field widths fixed by the sentence format.
	localparam int CharW   = 8;
	localparam int LenW    = 10;
	localparam int KindW   = 4;
	localparam int WaitW   = 8;
	localparam int TagCount = 8;

	// Reset value of the body length limit.
	localparam logic [LenW-1:0] MAX_BODY_LEN_RST = 10'd500;

	// Sentence kinds reported on the result channel.
	localparam logic [KindW-1:0] KIND_NONE = 4'd0;
	localparam logic [KindW-1:0] KIND_TXFK = 4'd1;
	localparam logic [KindW-1:0] KIND_ZTXX = 4'd7;

	// Special characters of the sentence format.
	localparam logic [CharW-1:0] CH_DOLLAR = 8'h24;
	localparam logic [CharW-1:0] CH_STAR   = 8'h2A;
	localparam logic [CharW-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CharW-1:0] CH_ZERO   = 8'h30;
	localparam logic [CharW-1:0] CH_NINE   = 8'h39;
	localparam logic [CharW-1:0] CH_NUL    = 8'h00;

	// Tag text, one row per kind in kind order, padded with zeros.
	localparam logic [CharW-1:0] TAG_TEXT [TagCount][8] = '{
		'{"T", "X", "F", "K", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"D", "W", "F", "K", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"T", "X", "X", "X", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"D", "W", "X", "X", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"G", "P", "R", "M", "C", 8'h00, 8'h00, 8'h00},
		'{"Y", "H", "X", "X", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"Z", "T", "X", "X", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"S", "J", "X", "X", 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] TAG_LEN [TagCount] = '{
		3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd4, 3'd4
	};

	// One input beat.
	typedef struct packed {
		logic [CharW-1:0] char_in;
		logic             is_last;
	} in_beat_t;

	// One result beat.
	typedef struct packed {
		logic             checksum_ok;
		logic [KindW-1:0] sentence_kind;
		logic             link_ready;
		logic [WaitW-1:0] wait_seconds;
		logic             send_confirmed;
	} out_beat_t;

	// Hex digit decode; any byte decodes, lowercase included.
	function automatic logic [3:0] hex_nibble(input logic [CharW-1:0] c);
		logic [CharW-1:0] v;
		v = c - CH_ZERO;
		if (v > 8'd9) begin
			v = v - 8'd7;
		end
		return v[3:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/nsc_parse.sv =====
// Per-sentence parse state: start, body XOR, length, tags, fields and verdict.
`default_nettype none
module nsc_parse (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire nsc_pkg::in_beat_t            beat,
	input  wire logic [nsc_pkg::LenW-1:0]     max_body_len,
	output nsc_pkg::out_beat_t                verdict
);

	typedef enum logic [2:0] {
		PH_START,
		PH_BODY,
		PH_HI,
		PH_LO,
		PH_DONE
	} phase_t;

	phase_t                          phase_q, n_phase;
	logic [nsc_pkg::CharW-1:0]       xor_q, n_xor;
	logic [nsc_pkg::LenW-1:0]        count_q, n_count;
	logic [3:0]                      hi_q, n_hi;
	logic [nsc_pkg::CharW-1:0]       rsum_q, n_rsum;
	logic [nsc_pkg::TagCount-1:0]    mask_q, n_mask;
	logic [3:0]                      field_q, n_field;
	logic [2:0]                      cif_q, n_cif;
	logic                            user_q, n_user;
	logic                            station_q, n_station;
	logic [nsc_pkg::WaitW-1:0]       wait_q, n_wait;
	logic                            confirm_q, n_confirm;
	logic                            reject_q, n_reject;
	logic                            live_q, n_live;

	logic [nsc_pkg::CharW-1:0]       c;
	logic                            over_len;
	logic [nsc_pkg::TagCount-1:0]    len_match;
	logic [nsc_pkg::TagCount-1:0]    char_match;
	logic [11:0]                     wait_sum;
	logic                            ok;
	logic [nsc_pkg::KindW-1:0]       kind;

	assign c = beat.char_in;

	// Body length check and wait accumulator arithmetic.
	assign over_len = {1'b0, count_q} > ({1'b0, max_body_len} + 11'd1);
	assign wait_sum = {1'b0, wait_q, 3'b000} + {3'b000, wait_q, 1'b0}
		+ {4'b0000, c - nsc_pkg::CH_ZERO};

	// Tag comparison against the current position of the first field.
	always_comb begin
		for (int k = 0; k < nsc_pkg::TagCount; k++) begin
			len_match[k]  = nsc_pkg::TAG_LEN[k] == cif_q;
			char_match[k] = (cif_q < nsc_pkg::TAG_LEN[k])
				&& (nsc_pkg::TAG_TEXT[k][cif_q] == c);
		end
	end

	// Next sentence state for the byte in hand.
	always_comb begin
		n_phase   = phase_q;
		n_xor     = xor_q;
		n_count   = count_q;
		n_hi      = hi_q;
		n_rsum    = rsum_q;
		n_mask    = mask_q;
		n_field   = field_q;
		n_cif     = cif_q;
		n_user    = user_q;
		n_station = station_q;
		n_wait    = wait_q;
		n_confirm = confirm_q;
		n_reject  = reject_q;
		n_live    = live_q;
		if (!reject_q) begin
			unique case (phase_q)
				PH_START: begin
					if (c == nsc_pkg::CH_DOLLAR) begin
						n_phase = PH_BODY;
					end else begin
						n_reject = 1'b1;
					end
				end
				PH_BODY: begin
					if (c == nsc_pkg::CH_STAR) begin
						if (field_q == 4'd0) begin
							n_mask = mask_q & len_match;
						end
						n_phase = PH_HI;
					end else if (c == nsc_pkg::CH_NUL || over_len) begin
						n_reject = 1'b1;
					end else begin
						n_xor = xor_q ^ c;
						if (count_q != {nsc_pkg::LenW{1'b1}}) begin
							n_count = count_q + 10'd1;
						end
						if (c == nsc_pkg::CH_COMMA) begin
							if (field_q == 4'd0) begin
								n_mask = mask_q & len_match;
							end
							if (field_q != 4'd15) begin
								n_field = field_q + 4'd1;
							end
							n_cif  = 3'd0;
							n_live = 1'b1;
						end else begin
							if (field_q == 4'd0) begin
								n_mask = mask_q & char_match;
							end else begin
								if (cif_q == 3'd0 && c == nsc_pkg::CH_ZERO) begin
									if (field_q == 4'd1) n_user    = 1'b1;
									if (field_q == 4'd2) n_confirm = 1'b1;
									if (field_q == 4'd3) n_station = 1'b1;
								end
								if (field_q == 4'd5 && live_q) begin
									if (c >= nsc_pkg::CH_ZERO && c <= nsc_pkg::CH_NINE) begin
										n_wait = (wait_sum > 12'd255) ? 8'd255 : wait_sum[7:0];
									end else begin
										n_live = 1'b0;
									end
								end
							end
							if (cif_q != 3'd7) begin
								n_cif = cif_q + 3'd1;
							end
						end
					end
				end
				PH_HI: begin
					if (c == nsc_pkg::CH_NUL) begin
						n_reject = 1'b1;
					end else begin
						n_hi    = nsc_pkg::hex_nibble(c);
						n_phase = PH_LO;
					end
				end
				PH_LO: begin
					if (c == nsc_pkg::CH_NUL) begin
						n_reject = 1'b1;
					end else begin
						n_rsum  = {hi_q, nsc_pkg::hex_nibble(c)};
						n_phase = PH_DONE;
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Verdict from the state after this byte; the lowest matching tag wins.
	always_comb begin
		ok   = !n_reject && n_phase == PH_DONE && n_rsum == n_xor;
		kind = nsc_pkg::KIND_NONE;
		if (ok) begin
			for (int k = nsc_pkg::TagCount - 1; k >= 0; k--) begin
				if (n_mask[k]) begin
					kind = nsc_pkg::KindW'(k + 1);
				end
			end
		end
		verdict.checksum_ok    = ok;
		verdict.sentence_kind  = kind;
		verdict.link_ready     = kind == nsc_pkg::KIND_ZTXX && n_user && n_station
			&& n_wait == 8'd0;
		verdict.wait_seconds   = (kind == nsc_pkg::KIND_ZTXX && n_user && n_station)
			? n_wait : 8'd0;
		verdict.send_confirmed = kind == nsc_pkg::KIND_TXFK && n_confirm;
	end

	// Sentence state; it returns to its start values after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			xor_q     <= '0;
			count_q   <= '0;
			hi_q      <= '0;
			rsum_q    <= '0;
			mask_q    <= '1;
			field_q   <= '0;
			cif_q     <= '0;
			user_q    <= 1'b0;
			station_q <= 1'b0;
			wait_q    <= '0;
			confirm_q <= 1'b0;
			reject_q  <= 1'b0;
			live_q    <= 1'b1;
		end else if (step) begin
			if (beat.is_last) begin
				phase_q   <= PH_START;
				xor_q     <= '0;
				count_q   <= '0;
				hi_q      <= '0;
				rsum_q    <= '0;
				mask_q    <= '1;
				field_q   <= '0;
				cif_q     <= '0;
				user_q    <= 1'b0;
				station_q <= 1'b0;
				wait_q    <= '0;
				confirm_q <= 1'b0;
				reject_q  <= 1'b0;
				live_q    <= 1'b1;
			end else begin
				phase_q   <= n_phase;
				xor_q     <= n_xor;
				count_q   <= n_count;
				hi_q      <= n_hi;
				rsum_q    <= n_rsum;
				mask_q    <= n_mask;
				field_q   <= n_field;
				cif_q     <= n_cif;
				user_q    <= n_user;
				station_q <= n_station;
				wait_q    <= n_wait;
				confirm_q <= n_confirm;
				reject_q  <= n_reject;
				live_q    <= n_live;
			end
		end
	end

	// Once rejected, a sentence never leaves its phase until it ends.
	a_reject_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		reject_q && step && !beat.is_last |=> reject_q && phase_q == $past(phase_q))
		else $error("rejected sentence changed phase");

	// The tag mask only loses candidates within a sentence.
	a_mask_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		step && !beat.is_last |=> (mask_q & ~$past(mask_q)) == '0)
		else $error("tag mask gained a candidate");

	// Counted body bytes only grow past the start of the body.
	a_count_zero_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_START |-> count_q == '0 && xor_q == '0)
		else $error("body state set before the dollar sign");

endmodule
`default_nettype wire

// ===== hdl/nmea_sentence_checker.sv =====
// NMEA sentence checker: checksum, length limit and tag classification.
//
// Usage: sentence bytes arrive on the input channel (in_valid, in_stall,
// in_data), one byte per beat, with is_last set on the final byte. Each
// sentence gives exactly one result beat on the output channel (out_valid,
// out_stall, out_data), carrying the checksum verdict, the sentence kind and
// the ZTXX and TXFK details. Bytes that are not last give no result.
// Throughput is one byte per cycle unless a last byte waits behind a stalled
// result. A byte is held in an input register and processed from there; the
// result of a last byte is then registered in the output register.
// The user must write the body length limit through cfg_we and cfg_wdata only
// while no sentence is in progress; the block does not enforce it. It resets to 500.
// Reset clears the sentence state, empties both registers and restores the
// limit. When the receiver stalls, the result stays in the output register;
// ordinary bytes keep being consumed, and in_stall rises only while a last
// byte waits behind a stalled result.
`default_nettype none
module nmea_sentence_checker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output      logic                      in_stall,
	input  wire nsc_pkg::in_beat_t         in_data,
	output      logic                      out_valid,
	input  wire logic                      out_stall,
	output      nsc_pkg::out_beat_t        out_data,
	input  wire logic                      cfg_we,
	input  wire logic [nsc_pkg::LenW-1:0]  cfg_wdata
);

	logic                           in_valid_s1;
	nsc_pkg::in_beat_t              beat_s1;
	logic                           out_valid_q;
	nsc_pkg::out_beat_t             out_data_q;
	logic [nsc_pkg::LenW-1:0]       max_body_len_q;
	logic                           blocked;
	logic                           step;
	nsc_pkg::out_beat_t             verdict;

	// A last byte waits only while the previous result is still held.
	assign blocked  = beat_s1.is_last && out_valid_q && out_stall;
	assign step     = in_valid_s1 && !blocked;
	assign in_stall = in_valid_s1 && blocked;

	// Body length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_len_q <= nsc_pkg::MAX_BODY_LEN_RST;
		end else if (cfg_we) begin
			max_body_len_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			beat_s1 <= in_data;
		end
	end

	nsc_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.beat         (beat_s1),
		.max_body_len (max_body_len_q),
		.verdict      (verdict)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && beat_s1.is_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && beat_s1.is_last) begin
			out_data_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Upstream is held back only by a last byte behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> beat_s1.is_last && out_valid_q && out_stall)
		else $error("input stalled without a held result");

	// A new result comes only from a processed last byte.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step && beat_s1.is_last))
		else $error("result appeared without a last byte");

	// A failed sentence never carries a kind.
	a_kind_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.checksum_ok |-> out_data_q.sentence_kind == nsc_pkg::KIND_NONE)
		else $error("kind reported on failed sentence");

	// Link readiness belongs to ZTXX sentences with no wait.
	a_ready_ztxx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.link_ready |->
			out_data_q.sentence_kind == nsc_pkg::KIND_ZTXX && out_data_q.wait_seconds == '0)
		else $error("link ready outside a ZTXX sentence");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the NMEA sentence checker: checksum, length limit and tags.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit  = 1000000;
	localparam int DrainCycles = 8;
	localparam int BodyCap     = 1023;
	localparam int MaxField    = 15;
	localparam int MaxPos      = 7;
	localparam int UserField    = 1;
	localparam int ConfirmField = 2;
	localparam int StationField = 3;
	localparam int WaitField    = 5;
	localparam int ZtxxRow = int'(nsc_pkg::KIND_ZTXX) - 1;
	localparam int TxfkRow = int'(nsc_pkg::KIND_TXFK) - 1;
	localparam logic [nsc_pkg::CharW-1:0] CH_FILL    = "Q";
	localparam logic [nsc_pkg::CharW-1:0] CH_UPPER_A = "A";
	localparam logic [nsc_pkg::CharW-1:0] CH_LOWER_A = "a";

	typedef enum logic [2:0] {
		AWAIT_DOLLAR, IN_BODY, HEX_HIGH, HEX_LOW, SUM_TAKEN
	} scan_phase_e;

	// Ways a generated sentence can be damaged.
	typedef enum int {
		FLAW_NONE, FLAW_NO_DOLLAR, FLAW_BAD_SUM, FLAW_CUT_STAR, FLAW_CUT_ONE,
		FLAW_NUL_BODY, FLAW_NUL_HEX, FLAW_TRAILER, FLAW_KINDS
	} flaw_e;

	typedef logic [nsc_pkg::CharW-1:0] text_q_t[$];

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	nsc_pkg::in_beat_t        in_data = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	nsc_pkg::out_beat_t       out_data;
	logic                     cfg_we = 1'b0;
	logic [nsc_pkg::LenW-1:0] cfg_wdata = '0;

	nsc_pkg::in_beat_t  byte_queue[$];
	nsc_pkg::out_beat_t verdicts_due[$];
	text_q_t            frame;

	int          errors = 0;
	int          queued = 0;
	int          bytes_taken = 0;
	int          verdicts_seen = 0;
	int          passes_seen = 0;
	int          settings = 0;
	int          cycles = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	logic        calm = 1'b0;
	logic [15:0] kinds_seen = '0;

	// Predicted state of the sentence scanner.
	logic [nsc_pkg::LenW-1:0]     body_limit = nsc_pkg::MAX_BODY_LEN_RST;
	scan_phase_e                  scan_phase = AWAIT_DOLLAR;
	logic [nsc_pkg::CharW-1:0]    xor_acc = '0;
	int                           body_len = 0;
	logic [3:0]                   hi_nib = '0;
	logic [nsc_pkg::CharW-1:0]    sum_rx = '0;
	logic [nsc_pkg::TagCount-1:0] tag_hits = '1;
	logic [3:0]                   field_no = '0;
	logic [2:0]                   field_pos = '0;
	logic                         user_zero = 1'b0;
	logic                         station_zero = 1'b0;
	logic [nsc_pkg::WaitW-1:0]    wait_acc = '0;
	logic                         txfk_zero = 1'b0;
	logic                         rejected = 1'b0;
	logic                         digits_live = 1'b1;

	nmea_sentence_checker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Gap lengths: mostly none, some short, a few long, none while calm.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Return the scanner to its state between sentences.
	task automatic clear_scan();
		scan_phase = AWAIT_DOLLAR;
		xor_acc = '0;
		body_len = 0;
		hi_nib = '0;
		sum_rx = '0;
		tag_hits = '1;
		field_no = '0;
		field_pos = '0;
		user_zero = 1'b0;
		station_zero = 1'b0;
		wait_acc = '0;
		txfk_zero = 1'b0;
		rejected = 1'b0;
		digits_live = 1'b1;
	endtask

	function automatic logic [3:0] nibble_of(input logic [nsc_pkg::CharW-1:0] c);
		logic [nsc_pkg::CharW-1:0] v;
		v = c - nsc_pkg::CH_ZERO;
		if (v > 8'd9) v = v - 8'd7;
		return v[3:0];
	endfunction

	// The first field ends: drop tags whose length differs.
	task automatic close_tag();
		for (int k = 0; k < nsc_pkg::TagCount; k++) begin
			if (int'(nsc_pkg::TAG_LEN[k]) != int'(field_pos)) tag_hits[k] = 1'b0;
		end
	endtask

	// Field tracking for one counted body character.
	task automatic track_fields(input logic [nsc_pkg::CharW-1:0] c);
		int w;
		if (c == nsc_pkg::CH_COMMA) begin
			if (field_no == 0) close_tag();
			if (field_no < MaxField) field_no++;
			field_pos = '0;
			digits_live = 1'b1;
		end else begin
			if (field_no == 0) begin
				for (int k = 0; k < nsc_pkg::TagCount; k++) begin
					if (int'(field_pos) >= int'(nsc_pkg::TAG_LEN[k])
						|| nsc_pkg::TAG_TEXT[k][field_pos] != c)
						tag_hits[k] = 1'b0;
				end
			end else begin
				if (field_pos == 0 && c == nsc_pkg::CH_ZERO) begin
					case (int'(field_no))
						UserField:    user_zero = 1'b1;
						ConfirmField: txfk_zero = 1'b1;
						StationField: station_zero = 1'b1;
						default: ;
					endcase
				end
				if (field_no == WaitField && digits_live) begin
					if (c >= nsc_pkg::CH_ZERO && c <= nsc_pkg::CH_NINE) begin
						w = int'(wait_acc) * 10 + int'(c) - int'(nsc_pkg::CH_ZERO);
						wait_acc = (w > 255) ? 8'd255 : nsc_pkg::WaitW'(w);
					end else begin
						digits_live = 1'b0;
					end
				end
			end
			if (field_pos < MaxPos) field_pos++;
		end
	endtask

	// Advance the scanner by one beat; a last beat yields the expected verdict.
	task automatic scan_sentence_byte(input nsc_pkg::in_beat_t b);
		logic [nsc_pkg::CharW-1:0] c;
		logic                      ok;
		logic [nsc_pkg::KindW-1:0] kind;
		nsc_pkg::out_beat_t        v;
		c = b.char_in;
		if (!rejected) begin
			case (scan_phase)
				AWAIT_DOLLAR: begin
					if (c == nsc_pkg::CH_DOLLAR) scan_phase = IN_BODY;
					else rejected = 1'b1;
				end
				IN_BODY: begin
					if (c == nsc_pkg::CH_STAR) begin
						if (field_no == 0) close_tag();
						scan_phase = HEX_HIGH;
					end else if (c == nsc_pkg::CH_NUL || body_len > int'(body_limit) + 1) begin
						rejected = 1'b1;
					end else begin
						xor_acc ^= c;
						if (body_len < BodyCap) body_len++;
						track_fields(c);
					end
				end
				HEX_HIGH: begin
					if (c == nsc_pkg::CH_NUL) rejected = 1'b1;
					else begin
						hi_nib = nibble_of(c);
						scan_phase = HEX_LOW;
					end
				end
				HEX_LOW: begin
					if (c == nsc_pkg::CH_NUL) rejected = 1'b1;
					else begin
						sum_rx = {hi_nib, nibble_of(c)};
						scan_phase = SUM_TAKEN;
					end
				end
				default: ;
			endcase
		end
		if (b.is_last) begin
			ok = !rejected && scan_phase == SUM_TAKEN && sum_rx == xor_acc;
			kind = nsc_pkg::KIND_NONE;
			if (ok) begin
				// The lowest surviving tag wins.
				for (int k = nsc_pkg::TagCount - 1; k >= 0; k--) begin
					if (tag_hits[k]) kind = nsc_pkg::KindW'(k + 1);
				end
			end
			v.checksum_ok = ok;
			v.sentence_kind = kind;
			v.link_ready = kind == nsc_pkg::KIND_ZTXX && user_zero && station_zero
				&& wait_acc == 0;
			v.wait_seconds = (kind == nsc_pkg::KIND_ZTXX && user_zero && station_zero)
				? wait_acc : '0;
			v.send_confirmed = kind == nsc_pkg::KIND_TXFK && txfk_zero;
			verdicts_due.push_back(v);
			clear_scan();
		end
	endtask

	// Follow register writes and accepted input beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_limit = nsc_pkg::MAX_BODY_LEN_RST;
			clear_scan();
		end else begin
			if (cfg_we) body_limit = cfg_wdata;
			if (in_valid && !in_stall) begin
				bytes_taken++;
				scan_sentence_byte(in_data);
			end
		end
	end

	// Input driver: present queued beats with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left = 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (byte_queue.size() > 0) begin
				in_data <= byte_queue.pop_front();
				in_valid <= 1'b1;
				gap_left = idle_length();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic compare_field(input string name, input logic [nsc_pkg::WaitW-1:0] want,
			input logic [nsc_pkg::WaitW-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Compare one result beat with the oldest predicted verdict.
	task automatic check_verdict(input nsc_pkg::out_beat_t got);
		nsc_pkg::out_beat_t want;
		if (verdicts_due.size() == 0) begin
			errors++;
			$display("%0t ns: result beat %h with no verdict expected", $time, got);
		end else begin
			want = verdicts_due.pop_front();
			verdicts_seen++;
			if (want.checksum_ok) passes_seen++;
			kinds_seen[want.sentence_kind] = 1'b1;
			compare_field("checksum_ok", nsc_pkg::WaitW'(want.checksum_ok),
				nsc_pkg::WaitW'(got.checksum_ok));
			compare_field("sentence_kind", nsc_pkg::WaitW'(want.sentence_kind),
				nsc_pkg::WaitW'(got.sentence_kind));
			compare_field("link_ready", nsc_pkg::WaitW'(want.link_ready),
				nsc_pkg::WaitW'(got.link_ready));
			compare_field("wait_seconds", want.wait_seconds, got.wait_seconds);
			compare_field("send_confirmed", nsc_pkg::WaitW'(want.send_confirmed),
				nsc_pkg::WaitW'(got.send_confirmed));
		end
	endtask

	// Output monitor: check accepted beats and stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) check_verdict(out_data);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = idle_length();
				out_stall <= 1'b0;
			end
		end
	end

	// Cycle count, calm stretches and the timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 256 == 0) calm <= ($urandom_range(0, 2) == 0);
		if (cycles >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding", cycles,
				verdicts_due.size());
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic logic [nsc_pkg::CharW-1:0] hex_char(input logic [3:0] n);
		logic [nsc_pkg::CharW-1:0] base;
		if (n < 4'd10) return nsc_pkg::CH_ZERO + nsc_pkg::CharW'(n);
		base = ($urandom_range(0, 3) == 0) ? CH_LOWER_A : CH_UPPER_A;
		return base + nsc_pkg::CharW'(n) - 8'd10;
	endfunction

	// Printable body character that neither ends the body nor splits a field.
	function automatic logic [nsc_pkg::CharW-1:0] text_char();
		logic [nsc_pkg::CharW-1:0] c;
		c = nsc_pkg::CharW'($urandom_range(32, 126));
		if (c == nsc_pkg::CH_STAR || c == nsc_pkg::CH_COMMA) c = CH_FILL;
		return c;
	endfunction

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
	endtask

	task automatic put_digits();
		repeat ($urandom_range(0, 5))
			frame.push_back(nsc_pkg::CH_ZERO + nsc_pkg::CharW'($urandom_range(0, 9)));
	endtask

	// Queue a byte sequence, marking its final byte as last.
	task automatic ship(input text_q_t line);
		nsc_pkg::in_beat_t b;
		foreach (line[i]) begin
			b.char_in = line[i];
			b.is_last = (i == line.size() - 1);
			byte_queue.push_back(b);
		end
		queued += line.size();
	endtask

	// Wrap the body in frame as a sentence with its checksum, then apply the given flaw.
	task automatic seal(input flaw_e flaw);
		logic [nsc_pkg::CharW-1:0] sum;
		text_q_t                   line;
		int                        idx;
		sum = '0;
		foreach (frame[i]) sum ^= frame[i];
		if (flaw == FLAW_BAD_SUM) sum ^= nsc_pkg::CharW'(1 << $urandom_range(0, 7));
		if (flaw == FLAW_NUL_BODY) frame.insert($urandom_range(0, frame.size()), nsc_pkg::CH_NUL);
		line.push_back(flaw == FLAW_NO_DOLLAR
			? nsc_pkg::CharW'($urandom_range(65, 90)) : nsc_pkg::CH_DOLLAR);
		foreach (frame[i]) line.push_back(frame[i]);
		line.push_back(nsc_pkg::CH_STAR);
		line.push_back(hex_char(sum[7:4]));
		line.push_back(hex_char(sum[3:0]));
		case (flaw)
			FLAW_CUT_STAR: repeat (2) void'(line.pop_back());
			FLAW_CUT_ONE:  void'(line.pop_back());
			FLAW_NUL_HEX: begin
				idx = line.size() - 1 - $urandom_range(0, 1);
				line[idx] = nsc_pkg::CH_NUL;
			end
			FLAW_TRAILER: begin
				repeat ($urandom_range(1, 4))
					line.push_back(nsc_pkg::CharW'($urandom_range(0, 255)));
			end
			default: ;
		endcase
		ship(line);
		frame.delete();
	endtask

	// Tag field: mostly real tags, ZTXX and TXFK favored, some cut, padded or replaced by random text.
	task automatic put_tag();
		int r, k, n;
		r = $urandom_range(0, 99);
		if (r < 30) k = ZtxxRow;
		else if (r < 50) k = TxfkRow;
		else k = $urandom_range(0, nsc_pkg::TagCount - 1);
		n = nsc_pkg::TAG_LEN[k];
		r = $urandom_range(0, 9);
		if (r == 0) n = $urandom_range(0, n - 1);
		for (int j = 0; j < n; j++) frame.push_back(nsc_pkg::TAG_TEXT[k][j]);
		if (r == 1) repeat ($urandom_range(1, 5)) frame.push_back(text_char());
		if (r == 2) begin
			frame.delete();
			repeat ($urandom_range(1, 9)) frame.push_back(text_char());
		end
	endtask

	task automatic put_field(input int idx);
		logic [nsc_pkg::CharW-1:0] c;
		if (idx == WaitField && $urandom_range(0, 1) == 1) begin
			case ($urandom_range(0, 4))
				0: put_text("-3");
				1: put_text(" 42");
				2: begin
					put_digits();
					frame.push_back(CH_FILL);
					put_digits();
				end
				default: put_digits();
			endcase
		end else begin
			case ($urandom_range(0, 4))
				0: ;
				1: frame.push_back(nsc_pkg::CH_ZERO);
				2: begin
					frame.push_back(nsc_pkg::CH_ZERO);
					repeat ($urandom_range(1, 3)) frame.push_back(text_char());
				end
				3: repeat ($urandom_range(1, 9)) frame.push_back(text_char());
				default: begin
					// Any nonzero byte but the star, high half included.
					repeat ($urandom_range(1, 4)) begin
						c = nsc_pkg::CharW'($urandom_range(1, 255));
						frame.push_back(c == nsc_pkg::CH_STAR ? CH_FILL : c);
					end
				end
			endcase
		end
	endtask

	task automatic put_body();
		int nf;
		put_tag();
		nf = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 7);
		for (int i = 1; i <= nf; i++) begin
			frame.push_back(nsc_pkg::CH_COMMA);
			put_field(i);
		end
	endtask

	task automatic noise_burst();
		text_q_t line;
		if ($urandom_range(0, 1) == 1) line.push_back(nsc_pkg::CH_DOLLAR);
		repeat ($urandom_range(1, 12)) line.push_back(nsc_pkg::CharW'($urandom_range(0, 255)));
		ship(line);
	endtask

	// Well-formed sentence whose body is exactly n bytes.
	task automatic filler_sentence(input int n);
		if (n > 20) put_text("ZTXX,0,,0,,9,");
		while (frame.size() < n) frame.push_back(text_char());
		seal(FLAW_NONE);
	endtask

	// Bodies of the longest accepted length (limit plus two) and one byte over it.
	task automatic limit_edge(input int lim);
		filler_sentence(lim + 2);
		filler_sentence(lim + 3);
	endtask

	task automatic random_sentences(input int count);
		int stop, r;
		stop = queued + count;
		while (queued < stop) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				noise_burst();
			end else begin
				put_body();
				if (r < 68) seal(FLAW_NONE);
				else seal(flaw_e'($urandom_range(1, int'(FLAW_KINDS) - 1)));
			end
		end
	endtask

	task automatic directed_sentences();
		text_q_t line;
		seal(FLAW_NONE);
		line.push_back(CH_FILL);
		ship(line);
		put_text("TXFK,1,0");
		seal(FLAW_NONE);
		put_text("ZTXX,0,a,0,b,0");
		seal(FLAW_NONE);
		put_text("ZTXX,0,,0,,300");
		seal(FLAW_NONE);
		put_text("ZTXX,0,,0,,-5");
		seal(FLAW_NONE);
		put_text("ZTXX,0,,1,,7");
		seal(FLAW_NONE);
		put_text("GPRMC,,,,,,,,,,,,,,,,,9");
		seal(FLAW_NONE);
		put_text("DWFK");
		seal(FLAW_CUT_STAR);
		put_text("DWXX");
		seal(FLAW_CUT_ONE);
		put_text("YHXX");
		seal(FLAW_NUL_BODY);
		put_text("SJXX");
		seal(FLAW_NUL_HEX);
		put_text("TXXX");
		seal(FLAW_TRAILER);
		put_text("TXFK,0,1");
		seal(FLAW_BAD_SUM);
		line.delete();
		line.push_back(8'hFF);
		ship(line);
	endtask

	// Wait until every queued beat went in and every verdict came back.
	task automatic wait_idle();
		do @(negedge clk);
		while (byte_queue.size() != 0 || in_valid || verdicts_due.size() != 0);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic set_limit(input logic [nsc_pkg::LenW-1:0] v);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
		@(negedge clk);
	endtask

	// Reset, then one phase per body length limit.
	initial begin
		int lim;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_sentences();
		limit_edge(int'(nsc_pkg::MAX_BODY_LEN_RST));
		random_sentences(250);

		set_limit('0);
		limit_edge(0);
		random_sentences(80);

		set_limit(10'd1023);
		random_sentences(100);

		set_limit(10'd1022);
		filler_sentence(1030);
		random_sentences(100);

		set_limit(10'd17);
		limit_edge(17);
		random_sentences(100);

		lim = $urandom_range(2, 60);
		set_limit(nsc_pkg::LenW'(lim));
		limit_edge(lim);
		random_sentences(100);

		set_limit(nsc_pkg::MAX_BODY_LEN_RST);
		random_sentences(80);

		wait_idle();
		$display("checked %0d verdicts over %0d bytes under %0d written limits, %0d passing",
			verdicts_seen, bytes_taken, settings, passes_seen);
		$display("sentence kinds reported, one bit per kind: %b",
			kinds_seen[nsc_pkg::TagCount:0]);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
